@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, register indexes, reset values and the command/status
// structs that join the stair floor counter controller and datapath.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int ALT_W       = 21;
  localparam int STEP_W      = 32;
  localparam int FH_W        = 11;
  localparam int THR_W       = 8;
  localparam int FLOOR_W     = 8;
  localparam int RISE_W      = ALT_W + 1;
  localparam int REM_W       = FH_W + 1;
  localparam int DIV_STEPS   = ALT_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);
  localparam int PROD_W      = FLOOR_W + FH_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = FH_W;
  localparam int IN_TDATA_W  = ((ALT_W + STEP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = FLOOR_W;

  localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(400);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE         = 2'd0,
    CFG_LEVEL_HEIGHT   = 2'd1,
    CFG_STEP_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load_in;
    logic capture;
    logic last_upd;
    logic base_to_alt;
    logic div_start;
    logic div_step;
    logic mul;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic first;
    logic rise_le0;
    logic ge;
    logic enough;
    logic div_last;
  } status_t;

endpackage

@@ rtl/sfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfc_ctrl
// Sequencer for the stair floor counter: takes a sample, picks the update
// path from datapath status, runs the divide, multiply and add steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module sfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  output logic             m_valid,
  input  logic             m_ready,
  input  sfc_pkg::status_t st,
  output sfc_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
        if (st.enable) begin
          if (st.first) begin
            cmd.capture = 1'b1;
          end else begin
            cmd.last_upd = 1'b1;
            if (st.rise_le0 || (st.ge && !st.enough)) begin
              cmd.base_to_alt = 1'b1;
            end else if (st.ge) begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sfc_dp.sv @@
// ----------------------------------------------------------------------------
// sfc_dp
// Datapath of the stair floor counter: configuration registers, tracking
// state, rise and step checks, a restoring divider one bit per cycle,
// the floors-times-height multiply and the output register.
// ----------------------------------------------------------------------------
module sfc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [sfc_pkg::ALT_W-1:0] in_alt,
  input  logic [sfc_pkg::STEP_W-1:0]       in_steps,
  input  sfc_pkg::cmd_t                    cmd,
  output sfc_pkg::status_t                 st,
  output logic [sfc_pkg::FLOOR_W-1:0]      out_floor,
  output logic                             out_acc
);

  logic                             enable;
  logic [sfc_pkg::FH_W-1:0]         level_height;
  logic [sfc_pkg::THR_W-1:0]        step_threshold;
  logic                             awaiting_first;
  logic signed [sfc_pkg::ALT_W-1:0] base;
  logic [sfc_pkg::STEP_W-1:0]       last_steps;
  logic [sfc_pkg::FLOOR_W-1:0]      floors;

  logic signed [sfc_pkg::ALT_W-1:0] alt;
  logic [sfc_pkg::STEP_W-1:0]       steps;
  logic [sfc_pkg::ALT_W-1:0]        dividend;
  logic [sfc_pkg::REM_W-1:0]        rem;
  logic [sfc_pkg::FLOOR_W-1:0]      quot;
  logic [sfc_pkg::DCNT_W-1:0]       cnt;
  logic [sfc_pkg::PROD_W-1:0]       prod;

  logic [sfc_pkg::FH_W-1:0]         h;
  logic [sfc_pkg::RISE_W-1:0]       rise;
  logic [sfc_pkg::STEP_W-1:0]       step_diff;
  logic [sfc_pkg::REM_W-1:0]        rem_shift;
  logic                             rem_ge;
  logic [sfc_pkg::REM_W-1:0]        rem_next;
  logic [sfc_pkg::RISE_W-1:0]       base_sum;

  assign h         = (level_height == '0) ? sfc_pkg::FH_W'(1) : level_height;
  assign rise      = {alt[sfc_pkg::ALT_W-1], alt} - {base[sfc_pkg::ALT_W-1], base};
  assign step_diff = steps - last_steps;
  assign rem_shift = {rem[sfc_pkg::REM_W-2:0], dividend[sfc_pkg::ALT_W-1]};
  assign rem_ge    = rem_shift >= sfc_pkg::REM_W'(h);
  assign rem_next  = rem_ge ? (rem_shift - sfc_pkg::REM_W'(h)) : rem_shift;
  assign base_sum  = {base[sfc_pkg::ALT_W-1], base} + sfc_pkg::RISE_W'(prod);

  always_comb begin
    st.enable   = enable;
    st.first    = awaiting_first;
    st.rise_le0 = rise[sfc_pkg::RISE_W-1] || (rise == '0);
    st.ge       = rise[sfc_pkg::ALT_W-1:0] >= sfc_pkg::ALT_W'(h);
    st.enough   = !step_diff[sfc_pkg::STEP_W-1] &&
                  (step_diff > sfc_pkg::STEP_W'(step_threshold));
    st.div_last = cnt == sfc_pkg::DCNT_W'(sfc_pkg::DIV_STEPS - 1);
  end

  // configuration and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      level_height   <= sfc_pkg::FH_RESET;
      step_threshold <= sfc_pkg::THR_RESET;
      awaiting_first <= 1'b1;
      base           <= '0;
      last_steps     <= '0;
      floors         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfc_pkg::CFG_ENABLE: begin
            enable <= cfg_data[0];
            if (cfg_data[0]) begin
              awaiting_first <= 1'b1;
            end
          end
          sfc_pkg::CFG_LEVEL_HEIGHT: begin
            level_height <= cfg_data;
          end
          sfc_pkg::CFG_STEP_THRESHOLD: begin
            step_threshold <= cfg_data[sfc_pkg::THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.capture) begin
        base           <= alt;
        floors         <= '0;
        last_steps     <= steps;
        awaiting_first <= 1'b0;
      end
      if (cmd.last_upd) begin
        last_steps <= steps;
      end
      if (cmd.base_to_alt) begin
        base <= alt;
      end
      if (cmd.add) begin
        base   <= base_sum[sfc_pkg::ALT_W-1:0];
        floors <= floors + quot;
      end
    end
  end

  // sample, divider, product and output registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      alt   <= in_alt;
      steps <= in_steps;
    end
    if (cmd.div_start) begin
      dividend <= rise[sfc_pkg::ALT_W-1:0];
      rem      <= '0;
      quot     <= '0;
      cnt      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[sfc_pkg::ALT_W-2:0], 1'b0};
      rem      <= rem_next;
      quot     <= {quot[sfc_pkg::FLOOR_W-2:0], rem_ge};
      cnt      <= cnt + sfc_pkg::DCNT_W'(1);
    end
    if (cmd.mul) begin
      prod <= sfc_pkg::PROD_W'(quot) * sfc_pkg::PROD_W'(h);
    end
    if (cmd.out_load) begin
      out_floor <= floors;
      out_acc   <= enable;
    end
  end

endmodule

@@ rtl/stair_floor_counter_core.sv @@
// ----------------------------------------------------------------------------
// stair_floor_counter_core
// Counts floors climbed from barometric altitude and pedometer steps.
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid/s_axis_tready    altitude_cm, step_count
//   m_axis    out   m_axis_tvalid/m_axis_tready    floor_total; tuser accepted
//   cfg       in    cfg_valid/cfg_ready            cfg_index, cfg_data
//
// A sample passes evaluate and done, plus divide, multiply and add when
// a climb is counted; the divide by the floor height gives one quotient
// bit per cycle. The output register holds a result while the next sample
// is taken. Reset gives enable off, floor height 400, step threshold 10.
// A stalled m_axis only stalls the finish of the following sample.
// ----------------------------------------------------------------------------
module stair_floor_counter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [20:0] altitude_cm, [52:21] step_count, [55:53] unused
  input  logic [sfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] floor_total
  output logic [sfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] accepted
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sfc_pkg::cmd_t    cmd;
  sfc_pkg::status_t st;

  assign cfg_ready = 1'b1;

  sfc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  sfc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_alt    (s_axis_tdata[sfc_pkg::ALT_W-1:0]),
    .in_steps  (s_axis_tdata[sfc_pkg::ALT_W +: sfc_pkg::STEP_W]),
    .cmd       (cmd),
    .st        (st),
    .out_floor (m_axis_tdata),
    .out_acc   (m_axis_tuser)
  );

endmodule

@@ rtl/sfc_checker.sv @@
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks for stair_floor_counter_core, bound to the top level.
// ----------------------------------------------------------------------------
module sfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("m_axis payload changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("sample taken while previous one still in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

endmodule

bind stair_floor_counter_core sfc_checker u_sfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
